@@ sv/servo_bus_response_receiver_core_assert.svh @@
// Assertion macros for the servo bus response receiver.
`ifndef SERVO_BUS_RESPONSE_RECEIVER_CORE_ASSERT_SVH
`define SERVO_BUS_RESPONSE_RECEIVER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SBRR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SBRR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/sbrr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sbrr_pkg;

  localparam int MAX_PARAMS = 4;

  localparam logic [7:0] HDR_BYTE = 8'h55;
  localparam logic [7:0] CMD_POS  = 8'd28;
  localparam logic [7:0] CMD_VIN  = 8'd27;
  localparam logic [7:0] CMD_TEMP = 8'd26;

  localparam logic [7:0]  SERVO_ID_RESET   = 8'h01;
  localparam logic [15:0] TIMEOUT_MS_RESET = 16'd100;

  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_SEND  = 2'd1;
  localparam logic [1:0] REQ_CHECK = 2'd2;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_ACCEPT  = 2'd1;
  localparam logic [1:0] EV_REJECT  = 2'd2;
  localparam logic [1:0] EV_TIMEOUT = 2'd3;

  // Register indexes on the configuration port (byte address bit 2).
  localparam logic REG_SERVO_ID   = 1'b0;
  localparam logic REG_TIMEOUT_MS = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_ADDR,
    PH_LEN,
    PH_BODY
  } phase_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  resp_cmd;
    logic [15:0] position_ticks;
    logic [15:0] voltage_mv;
    logic [7:0]  temperature_c;
    logic        waiting;
    logic        timeout_fault;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  servo_id;
    logic [15:0] timeout_ms;
  } cfg_t;

endpackage

`default_nettype wire

@@ sv/servo_bus_response_receiver_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Servo bus response receiver. Each transaction on the request channel carries
// one received bus byte, a request-sent notice (arms the reply timeout with
// now_ms) or a time check, and produces exactly one response transaction, held in
// the output buffer. A new request is taken every cycle while req_stall is low:
// the parser keeps a running checksum so each byte is finished in a single pass,
// and a two-entry output buffer (result register plus skid entry) lets one more
// request in while a result is stalled. req_stall rises only while both entries
// are full. servo_id sits at byte address 0 and timeout_ms at byte address 4.

`include "servo_bus_response_receiver_core_assert.svh"

module servo_bus_response_receiver_core
  import sbrr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire req_t        req_data,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output rsp_t             rsp_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t cfg;
  rsp_t result;
  logic accept;
  logic full;

  assign req_stall = full;
  assign accept    = req_valid && !req_stall;

  sbrr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sbrr_frame_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req_data),
    .cfg    (cfg),
    .rsp    (result)
  );

  sbrr_out_buffer u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .load_data (result),
    .full      (full),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  `SBRR_ASSERT_NOW(a_stall_needs_result, clk, rst, req_stall, rsp_valid,
                   "stall with no result held")
  `SBRR_ASSERT_NEXT(a_stall_clears, clk, rst, req_stall && !rsp_stall, !req_stall,
                    "skid did not drain")
  `SBRR_ASSERT_NOW(a_accept_clears_wait, clk, rst,
                   rsp_valid && rsp_data.event_res == EV_ACCEPT, !rsp_data.waiting,
                   "waiting set after accepted frame")
  `SBRR_ASSERT_NOW(a_timeout_faults, clk, rst,
                   rsp_valid && rsp_data.event_res == EV_TIMEOUT,
                   rsp_data.timeout_fault && !rsp_data.waiting,
                   "timeout without fault")

endmodule

`default_nettype wire

@@ sv/sbrr_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sbrr_cfg_regs
  import sbrr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic [7:0]  servo_id;
  logic [15:0] timeout_ms;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      servo_id   <= SERVO_ID_RESET;
      timeout_ms <= TIMEOUT_MS_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_SERVO_ID:   servo_id   <= pwdata[7:0];
        REG_TIMEOUT_MS: timeout_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SERVO_ID:   prdata = {24'd0, servo_id};
      REG_TIMEOUT_MS: prdata = {16'd0, timeout_ms};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg.servo_id   = servo_id;
  assign cfg.timeout_ms = timeout_ms;

endmodule

`default_nettype wire

@@ sv/sbrr_frame_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sbrr_frame_parser
  import sbrr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic accept,
  input  wire req_t req,
  input  wire cfg_t cfg,
  output rsp_t      rsp
);

  phase_t      phase, phase_next;
  logic [3:0]  byte_index, byte_index_next;
  logic [3:0]  frame_total, frame_total_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  frame_addr, frame_addr_next;
  logic [7:0]  frame_cmd, frame_cmd_next;
  logic [7:0]  param_store [MAX_PARAMS];
  logic        awaiting_reply, awaiting_reply_next;
  logic [31:0] request_stamp, request_stamp_next;
  logic        fault_bit, fault_bit_next;
  logic [15:0] position_reg, position_reg_next;
  logic [15:0] voltage_reg, voltage_reg_next;
  logic [7:0]  temperature_reg, temperature_reg_next;

  logic [7:0]  b;
  logic        is_byte;
  logic [3:0]  idx_inc;
  logic [1:0]  param_off;
  logic [3:0]  nparams;
  logic        in_body;
  logic        frame_ok;
  logic        param_we;
  logic [31:0] elapsed;
  logic [1:0]  ev;
  logic [7:0]  cmd_out;

  assign b         = req.rx_byte;
  assign is_byte   = (req.req_type == REQ_BYTE);
  assign idx_inc   = byte_index + 4'd1;
  assign param_off = 2'(byte_index - 4'd5);
  assign nparams   = frame_total - 4'd6;
  assign in_body   = (idx_inc < frame_total);
  assign frame_ok  = (b == ~running_sum) && (frame_addr == cfg.servo_id);
  assign elapsed   = req.now_ms - request_stamp;

  // Header and length tracking.
  always_comb begin
    phase_next       = phase;
    byte_index_next  = byte_index;
    frame_total_next = frame_total;
    if (is_byte) begin
      case (phase)
        PH_HUNT1: begin
          if (b == HDR_BYTE) begin
            phase_next      = PH_HUNT2;
            byte_index_next = 4'd1;
          end
        end
        PH_HUNT2: begin
          if (b == HDR_BYTE) begin
            phase_next      = PH_ADDR;
            byte_index_next = 4'd2;
          end else begin
            phase_next       = PH_HUNT1;
            byte_index_next  = 4'd0;
            frame_total_next = 4'd0;
          end
        end
        PH_ADDR: begin
          phase_next      = PH_LEN;
          byte_index_next = 4'd3;
        end
        PH_LEN: begin
          if (b inside {[8'd3:8'd7]}) begin
            phase_next       = PH_BODY;
            byte_index_next  = 4'd4;
            frame_total_next = b[3:0] + 4'd3;
          end else begin
            phase_next       = PH_HUNT1;
            byte_index_next  = 4'd0;
            frame_total_next = 4'd0;
          end
        end
        PH_BODY: begin
          if (in_body) begin
            byte_index_next = idx_inc;
          end else begin
            phase_next       = PH_HUNT1;
            byte_index_next  = 4'd0;
            frame_total_next = 4'd0;
          end
        end
        default: begin
          phase_next       = PH_HUNT1;
          byte_index_next  = 4'd0;
          frame_total_next = 4'd0;
        end
      endcase
    end
  end

  // Checksum, frame fields, raw registers, timeout and result.
  always_comb begin
    running_sum_next     = running_sum;
    frame_addr_next      = frame_addr;
    frame_cmd_next       = frame_cmd;
    awaiting_reply_next  = awaiting_reply;
    request_stamp_next   = request_stamp;
    fault_bit_next       = fault_bit;
    position_reg_next    = position_reg;
    voltage_reg_next     = voltage_reg;
    temperature_reg_next = temperature_reg;
    param_we             = 1'b0;
    ev                   = EV_NONE;
    cmd_out              = 8'd0;
    case (req.req_type)
      REQ_BYTE: begin
        case (phase)
          PH_HUNT1: ;
          PH_HUNT2: begin
            if (b != HDR_BYTE) running_sum_next = 8'd0;
          end
          PH_ADDR: begin
            frame_addr_next  = b;
            running_sum_next = b;
          end
          PH_LEN: begin
            if (b inside {[8'd3:8'd7]}) running_sum_next = running_sum + b;
            else running_sum_next = 8'd0;
          end
          PH_BODY: begin
            if (in_body) begin
              if (byte_index == 4'd4) frame_cmd_next = b;
              else param_we = (byte_index inside {[4'd5:4'd8]});
              running_sum_next = running_sum + b;
            end else begin
              // checksum byte closes the frame
              running_sum_next = 8'd0;
              cmd_out          = frame_cmd;
              if (!frame_ok) begin
                ev = EV_REJECT;
              end else begin
                ev                  = EV_ACCEPT;
                awaiting_reply_next = 1'b0;
                if (frame_cmd == CMD_POS && nparams >= 4'd2)
                  position_reg_next = {param_store[1], param_store[0]};
                else if (frame_cmd == CMD_VIN && nparams >= 4'd2)
                  voltage_reg_next = {param_store[1], param_store[0]};
                else if (frame_cmd == CMD_TEMP && nparams >= 4'd1)
                  temperature_reg_next = param_store[0];
              end
            end
          end
          default: running_sum_next = 8'd0;
        endcase
      end
      REQ_SEND: begin
        awaiting_reply_next = 1'b1;
        request_stamp_next  = req.now_ms;
      end
      REQ_CHECK: begin
        if (awaiting_reply && elapsed > {16'd0, cfg.timeout_ms}) begin
          awaiting_reply_next = 1'b0;
          fault_bit_next      = 1'b1;
          ev                  = EV_TIMEOUT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT1;
      byte_index      <= 4'd0;
      frame_total     <= 4'd0;
      running_sum     <= 8'd0;
      frame_addr      <= 8'd0;
      frame_cmd       <= 8'd0;
      awaiting_reply  <= 1'b0;
      request_stamp   <= 32'd0;
      fault_bit       <= 1'b0;
      position_reg    <= 16'd0;
      voltage_reg     <= 16'd0;
      temperature_reg <= 8'd0;
    end else if (accept) begin
      phase           <= phase_next;
      byte_index      <= byte_index_next;
      frame_total     <= frame_total_next;
      running_sum     <= running_sum_next;
      frame_addr      <= frame_addr_next;
      frame_cmd       <= frame_cmd_next;
      awaiting_reply  <= awaiting_reply_next;
      request_stamp   <= request_stamp_next;
      fault_bit       <= fault_bit_next;
      position_reg    <= position_reg_next;
      voltage_reg     <= voltage_reg_next;
      temperature_reg <= temperature_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_byte && param_we) param_store[param_off] <= b;
  end

  assign rsp.event_res      = ev;
  assign rsp.resp_cmd       = cmd_out;
  assign rsp.position_ticks = position_reg_next;
  assign rsp.voltage_mv     = voltage_reg_next;
  assign rsp.temperature_c  = temperature_reg_next;
  assign rsp.waiting        = awaiting_reply_next;
  assign rsp.timeout_fault  = fault_bit_next;

endmodule

`default_nettype wire

@@ sv/sbrr_out_buffer.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sbrr_out_buffer
  import sbrr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic load,
  input  wire rsp_t load_data,
  output logic      full,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp_data
);

  rsp_t skid_data;
  logic skid_valid;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!rsp_valid || !rsp_stall) begin
      // advance: drain the skid entry first
      if (skid_valid) begin
        rsp_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        rsp_valid <= load;
      end
    end else if (load) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rsp_valid || !rsp_stall) begin
      if (skid_valid) rsp_data <= skid_data;
      else if (load) rsp_data <= load_data;
    end else if (load) begin
      skid_data <= load_data;
    end
  end

endmodule

`default_nettype wire
